// File: rtl/core/itp_pkg.sv
// Shared constants and helpers for the integer text parser.
// Holds default widths, character codes, register indexes and the digit decoder.
// Depends on nothing.
package itp_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int COUNT_BITS_DEF = 16;

    localparam int BASE_W = 5;
    localparam int END_W  = 16;

    // Register indexes on the configuration port.
    localparam logic REG_RADIX  = 1'b0;
    localparam logic REG_SIGNED = 1'b1;

    localparam logic [BASE_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [BASE_W-1:0] BASE_DEC    = 5'd10;
    localparam logic [BASE_W-1:0] BASE_OCT    = 5'd8;
    localparam logic [BASE_W-1:0] BASE_HEX    = 5'd16;
    localparam logic [BASE_W-1:0] BASE_AUTO   = 5'd0;

    // Decoder result that marks a byte which is not a digit in any base.
    localparam logic [BASE_W-1:0] DIGIT_NONE = 5'd16;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    // Value of a hex digit character, or DIGIT_NONE for any other byte.
    function automatic logic [BASE_W-1:0] digit_of(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            t = c - CH_ZERO;
            return t[BASE_W-1:0];
        end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            t = c - CH_LO_A + 8'd10;
            return t[BASE_W-1:0];
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            t = c - CH_UP_A + 8'd10;
            return t[BASE_W-1:0];
        end
        return DIGIT_NONE;
    endfunction

endpackage

// File: rtl/core/integer_text_parser.sv
// Streaming integer text parser in the manner of strtol and strtoul.
// A result beat is presented in the cycle after the character that ends the parse.
// Throughput: one character beat per cycle while o_in_ready is high; the accumulator
// multiply-add by the base and digit compare are combinational before the registers.
// Reset (synchronous, active low) returns to idle with radix 10 and signed mode on.
// Depends on itp_pkg.
module integer_text_parser #(
    parameter int VALUE_BITS = itp_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = itp_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Character stream.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_start_req,

    // Result stream.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_value,
    output logic [15:0] o_end_offset,
    output logic        o_no_digits,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Parse phases. Codes above PH_DIGITS never occur and fall back to idle.
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_LEAD   = 3'd1;
    localparam logic [2:0] PH_PRE    = 3'd2;
    localparam logic [2:0] PH_ZERO   = 3'd3;
    localparam logic [2:0] PH_HEXPFX = 3'd4;
    localparam logic [2:0] PH_DIGITS = 3'd5;

    localparam int BW = itp_pkg::BASE_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // Configuration registers.
    logic [BW-1:0] r_radix;
    logic          r_signed;

    // Parse state.
    logic [2:0]            r_phase, n_phase;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic                  r_neg, n_neg;
    logic [BW-1:0]         r_base, n_base;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic                  r_seen, n_seen;

    // Result register.
    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_value, n_value;
    logic [15:0]           r_end, n_end;
    logic                  r_nodig, n_nodig;

    logic in_accept;
    logic emit;
    logic cfg_write;

    // The input side moves whenever the result register is free or is being drained,
    // so a finished result holds up the next character only until it is taken.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    // Next-state logic: the phases fall through one another within the same beat,
    // exactly as a character that is not consumed by one phase is offered to the next.
    always_comb begin
        logic                  go;
        logic [BW-1:0]         d;
        logic [VALUE_BITS-1:0] prod;
        logic [VALUE_BITS-1:0] fin_acc;
        logic [COUNT_BITS-1:0] fin_cnt;
        logic                  fin_now;

        n_phase = r_phase;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_base  = r_base;
        n_cnt   = r_cnt;
        n_seen  = r_seen;
        emit    = 1'b0;
        go      = 1'b1;
        fin_now = 1'b0;
        fin_cnt = r_cnt;
        d       = itp_pkg::digit_of(i_ch);

        if (i_start_req) begin
            n_acc   = '0;
            n_neg   = 1'b0;
            n_seen  = 1'b0;
            n_cnt   = '0;
            n_base  = r_radix;
            n_phase = PH_LEAD;
        end else if (r_phase == PH_IDLE || r_phase > PH_DIGITS) begin
            // Characters outside a parse are dropped.
            n_phase = PH_IDLE;
            go      = 1'b0;
        end

        // Whitespace and sign.
        if (go && n_phase == PH_LEAD) begin
            if (i_ch inside {itp_pkg::CH_SPACE, itp_pkg::CH_TAB,
                             itp_pkg::CH_LF, itp_pkg::CH_CR}) begin
                go = 1'b0;
            end else if (i_ch == itp_pkg::CH_MINUS && r_signed) begin
                n_neg   = 1'b1;
                n_phase = PH_PRE;
                go      = 1'b0;
            end else if (i_ch == itp_pkg::CH_PLUS) begin
                n_phase = PH_PRE;
                go      = 1'b0;
            end else begin
                n_phase = PH_PRE;
            end
        end

        // A leading zero may open a hex prefix or, in auto mode, select octal.
        if (go && n_phase == PH_PRE) begin
            if (i_ch == itp_pkg::CH_ZERO &&
                (n_base == itp_pkg::BASE_AUTO || n_base == itp_pkg::BASE_HEX)) begin
                n_acc   = '0;
                n_seen  = 1'b1;
                n_phase = PH_ZERO;
                go      = 1'b0;
            end else begin
                if (n_base == itp_pkg::BASE_AUTO) begin
                    n_base = itp_pkg::BASE_DEC;
                end
                n_phase = PH_DIGITS;
            end
        end

        if (go && n_phase == PH_ZERO) begin
            if (i_ch == itp_pkg::CH_LO_X || i_ch == itp_pkg::CH_UP_X) begin
                n_base  = itp_pkg::BASE_HEX;
                n_phase = PH_HEXPFX;
                go      = 1'b0;
            end else begin
                if (n_base == itp_pkg::BASE_AUTO) begin
                    n_base = itp_pkg::BASE_OCT;
                end
                n_phase = PH_DIGITS;
            end
        end

        // After "0x" a hex digit must follow; otherwise the lone zero is the number
        // and the end position points back at the 'x'.
        if (go && n_phase == PH_HEXPFX) begin
            if (d < itp_pkg::DIGIT_NONE) begin
                n_acc   = VALUE_BITS'(d);
                n_phase = PH_DIGITS;
                go      = 1'b0;
            end else begin
                fin_now = 1'b1;
                fin_cnt = (n_cnt != '0) ? n_cnt - 1'b1 : '0;
                go      = 1'b0;
            end
        end

        prod = n_acc * VALUE_BITS'(n_base);
        if (go && n_phase == PH_DIGITS) begin
            if (d < n_base) begin
                n_acc  = prod + VALUE_BITS'(d);
                n_seen = 1'b1;
            end else begin
                fin_now = 1'b1;
                fin_cnt = n_cnt;
            end
            go = 1'b0;
        end

        // Every consumed character advances the saturating counter once.
        if (n_phase != PH_IDLE && !fin_now && n_cnt != CNT_MAX) begin
            n_cnt = n_cnt + 1'b1;
        end

        fin_acc = n_neg ? ('0 - n_acc) : n_acc;
        n_value = '0;
        n_end   = '0;
        n_nodig = 1'b1;
        if (fin_now) begin
            emit    = 1'b1;
            n_phase = PH_IDLE;
            if (n_seen) begin
                n_value = fin_acc;
                n_end   = 16'(fin_cnt);
                n_nodig = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_base  <= '0;
            r_cnt   <= '0;
            r_seen  <= 1'b0;
        end else if (in_accept) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_base  <= n_base;
            r_cnt   <= n_cnt;
            r_seen  <= n_seen;
        end
    end

    // Result register: loaded when a parse ends, emptied when the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && emit) begin
            r_value <= n_value;
            r_end   <= n_end;
            r_nodig <= n_nodig;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_value      = 64'(r_value);
    assign o_end_offset = r_end;
    assign o_no_digits  = r_nodig;

    // Configuration registers decode on address bit 2 only; the radix is latched
    // into the parse at each start, the sign mode is read when a sign arrives.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= itp_pkg::RADIX_RESET;
            r_signed <= 1'b1;
        end else if (cfg_write) begin
            if (paddr[2] == itp_pkg::REG_RADIX) begin
                r_radix <= pwdata[BW-1:0];
            end else begin
                r_signed <= pwdata[0];
            end
        end
    end

    assign prdata = (paddr[2] == itp_pkg::REG_SIGNED) ? {31'd0, r_signed}
                                                       : {{(32-BW){1'b0}}, r_radix};

`ifndef SYNTH
    // A character outside a parse never produces a result.
    a_idle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_start_req && r_phase == PH_IDLE) |=> !o_out_valid)
        else $error("result produced from an idle character");

    // The parse returns to idle after a result.
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && emit) |=> (r_phase == PH_IDLE && o_out_valid))
        else $error("parse not closed after a result");

    // A failed conversion reports zero value and zero offset.
    a_nodig_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_no_digits) |-> (o_value == 64'd0 && o_end_offset == 16'd0))
        else $error("nonzero fields on a failed conversion");
`endif

endmodule
